// ===== design/spreading_code_correlator_defines.svh =====
// Assertion macros used by the correlator's top-level RTL file.
`ifndef SPREADING_CODE_CORRELATOR_DEFINES_SVH
`define SPREADING_CODE_CORRELATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define SCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SCC_ASSERT(label, prop, msg)
`define SCC_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== design/scc_pkg.sv =====
// Types and constants of the spreading code correlator.
package scc_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned CORR_BITS    = 24;
  localparam int unsigned CHIP_REGS    = 4;
  localparam int unsigned CHIP_REG_W   = 64;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned DEFAULT_TAPS = 128;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_CHIPS_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_CHIPS_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_CHIPS_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_CHIPS_3 = 3'd3;

  typedef enum logic [1:0] {
    CHIP_POS_ONE = 2'd0,
    CHIP_NEG_J   = 2'd1,
    CHIP_NEG_ONE = 2'd2,
    CHIP_POS_J   = 2'd3
  } chip_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [CORR_BITS-1:0] corr_re;
    logic signed [CORR_BITS-1:0] corr_im;
  } out_item_t;

  // One partial sum travelling down the chain.
  typedef struct packed {
    logic                        valid;
    logic signed [CORR_BITS-1:0] re;
    logic signed [CORR_BITS-1:0] im;
  } sum_t;

endpackage

// ===== design/scc_cell.sv =====
// One correlator cell: holds a window sample and adds its chip product to the passing sum.
module scc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  scc_pkg::chip_e    chip_i,
  input  scc_pkg::in_item_t smp_i,
  output scc_pkg::in_item_t smp_o,
  input  scc_pkg::sum_t     sum_i,
  output scc_pkg::sum_t     sum_o
);
  import scc_pkg::*;

  in_item_t                    smp_q;
  logic                        sum_vld_q;
  logic signed [CORR_BITS-1:0] sum_re_q, sum_im_q;
  logic signed [CORR_BITS-1:0] a, b, t_re, t_im, sum_re_d, sum_im_d;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      smp_q <= smp_i;
    end
  end

  assign a = {{(CORR_BITS-SAMPLE_BITS){smp_q.sample_re[SAMPLE_BITS-1]}}, smp_q.sample_re};
  assign b = {{(CORR_BITS-SAMPLE_BITS){smp_q.sample_im[SAMPLE_BITS-1]}}, smp_q.sample_im};

  // Each chip is a multiple of a quarter turn: only swaps and negations are needed.
  always_comb begin
    case (chip_i)
      CHIP_POS_ONE: begin t_re = a;  t_im = b;  end
      CHIP_NEG_J:   begin t_re = b;  t_im = -a; end
      CHIP_NEG_ONE: begin t_re = -a; t_im = -b; end
      CHIP_POS_J:   begin t_re = -b; t_im = a;  end
      default:      begin t_re = a;  t_im = b;  end
    endcase
  end

  assign sum_re_d = sum_i.re + t_re;
  assign sum_im_d = sum_i.im + t_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else begin
      sum_vld_q <= sum_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_i.valid) begin
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
    end
  end

  assign smp_o       = smp_q;
  assign sum_o.valid = sum_vld_q;
  assign sum_o.re    = sum_re_q;
  assign sum_o.im    = sum_im_q;

endmodule

// ===== design/spreading_code_correlator.sv =====
// Complex correlator against a programmable quaternary spreading code: a chain of sample cells.
// An item that fills the window starts a partial sum, registered in start_q, that walks the
// cell chain one cell per cycle and then passes through a holding register and the output
// register; a new item is taken only once the sum has left the chain and its holding register.
// Items taken before the window is full give no result and are taken one per cycle.
// Reset clears the code registers, the fill count and all valid flags; window samples are not.
module spreading_code_correlator #(
  parameter int unsigned TAPS = scc_pkg::DEFAULT_TAPS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  scc_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output scc_pkg::out_item_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [scc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [scc_pkg::CHIP_REG_W-1:0]   cfg_data_i
);
  import scc_pkg::*;

  `include "spreading_code_correlator_defines.svh"

  localparam int unsigned FILL_W = $clog2(TAPS + 1);

  logic [CHIP_REGS-1:0][CHIP_REG_W-1:0] code_q;
  logic [CHIP_REGS*CHIP_REG_W-1:0]      code_flat;
  logic [FILL_W-1:0]                    fill_q;
  logic                                 start_q, busy_q, pend_vld_q, out_vld_q;
  out_item_t                            pend_q, out_q;
  logic                                 in_acc, fills, pend_move;
  in_item_t                             smp_w [TAPS+1];
  sum_t                                 sum_w [TAPS+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CODE_CHIPS_0: code_q[0] <= cfg_data_i;
        REG_CODE_CHIPS_1: code_q[1] <= cfg_data_i;
        REG_CODE_CHIPS_2: code_q[2] <= cfg_data_i;
        REG_CODE_CHIPS_3: code_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign code_flat = code_q;

  assign in_stall_o = busy_q || pend_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  // This item completes the window or shifts a full one, so it starts a sum down the chain.
  assign fills      = fill_q >= FILL_W'(TAPS - 1);
  assign pend_move  = pend_vld_q && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      start_q    <= 1'b0;
      busy_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      start_q <= in_acc && fills;
      if (in_acc && (fill_q != FILL_W'(TAPS))) begin
        fill_q <= fill_q + 1'b1;
      end
      if (in_acc && fills) begin
        busy_q <= 1'b1;
      end else if (sum_w[TAPS].valid) begin
        busy_q <= 1'b0;
      end
      if (sum_w[TAPS].valid) begin
        pend_vld_q <= 1'b1;
      end else if (pend_move) begin
        pend_vld_q <= 1'b0;
      end
      if (pend_move) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_w[TAPS].valid) begin
      pend_q.corr_re <= sum_w[TAPS].re;
      pend_q.corr_im <= sum_w[TAPS].im;
    end
    if (pend_move) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Samples enter at the newest end and move toward cell 0, the oldest position.
  assign smp_w[TAPS] = in_data_i;
  assign sum_w[0]    = '{valid: start_q, re: '0, im: '0};

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    scc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .chip_i  (chip_e'(code_flat[2*k +: 2])),
      .smp_i   (smp_w[k+1]),
      .smp_o   (smp_w[k]),
      .sum_i   (sum_w[k]),
      .sum_o   (sum_w[k+1])
    );
  end

  `SCC_ASSERT(a_sum_lands_free, sum_w[TAPS].valid |-> !pend_vld_q, "sum hit a full register")
  `SCC_ASSERT(a_sum_while_busy, sum_w[TAPS].valid |-> busy_q, "sum left the chain while not busy")
  `SCC_ASSERT(a_start_when_full, start_q |-> fill_q == FILL_W'(TAPS), "sum on a partial window")
  `SCC_ASSERT_NEVER(a_pend_busy, pend_vld_q && busy_q, "held result while a sum is in flight")

endmodule

// ===== tb/sv/spreading_code_correlator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the quaternary spreading code correlator.
module spreading_code_correlator_tb;
  import scc_pkg::*;

  localparam int unsigned TAPS = DEFAULT_TAPS;
  // Indexes past the last code register; writes there must leave the code alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_CODE_CHIPS_3 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CHIP_REG_W-1:0] cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;

  // Mirror of the block: code registers, sample history (oldest first) and fill level.
  logic [CHIP_REG_W-1:0]         code_word [CHIP_REGS];
  logic signed [SAMPLE_BITS-1:0] hist_re [TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_im [TAPS];
  int unsigned                   samples_held = 0;
  out_item_t                     expected_corr [$];
  out_item_t                     want;

  spreading_code_correlator #(
    .TAPS(TAPS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    foreach (code_word[i]) code_word[i] = '0;
  end

  // Shift the new sample into the history and, once the window is full,
  // queue the complex correlation of the window against the chip code.
  function automatic void correlate_sample(input in_item_t s);
    int    acc_re;
    int    acc_im;
    int    a;
    int    b;
    chip_e chip;
    out_item_t r;
    acc_re = 0;
    acc_im = 0;
    for (int k = 0; k < TAPS - 1; k++) begin
      hist_re[k] = hist_re[k + 1];
      hist_im[k] = hist_im[k + 1];
    end
    hist_re[TAPS - 1] = s.sample_re;
    hist_im[TAPS - 1] = s.sample_im;
    if (samples_held < TAPS) samples_held++;
    if (samples_held == TAPS) begin
      for (int k = 0; k < TAPS; k++) begin
        a = hist_re[k];
        b = hist_im[k];
        chip = chip_e'(code_word[k / 32][(k % 32) * 2 +: 2]);
        case (chip)
          CHIP_POS_ONE: begin
            acc_re += a;
            acc_im += b;
          end
          CHIP_NEG_J: begin
            acc_re += b;
            acc_im -= a;
          end
          CHIP_NEG_ONE: begin
            acc_re -= a;
            acc_im -= b;
          end
          default: begin
            acc_re -= b;
            acc_im += a;
          end
        endcase
      end
      r.corr_re = acc_re[CORR_BITS-1:0];
      r.corr_im = acc_im[CORR_BITS-1:0];
      expected_corr.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_corr.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected item: re %0d im %0d", out_data.corr_re, out_data.corr_im);
        end
      end else begin
        want = expected_corr.pop_front();
        if (out_data.corr_re !== want.corr_re || out_data.corr_im !== want.corr_im) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected re %0d im %0d, got re %0d im %0d",
                     want.corr_re, want.corr_im, out_data.corr_re, out_data.corr_im);
          end
        end
      end
    end
  end

  // Valid stays high from one item to the next unless a gap is chosen.
  task automatic send_sample(input in_item_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    correlate_sample(s);
  endtask

  // Items that only fill the window give no result, so allow the chain to settle too.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_corr.size() != 0) @(posedge clk);
    repeat (TAPS + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHIP_REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_CODE_CHIPS_3) code_word[idx] = val;
  endtask

  // Writes all four code registers, then a stray write to an unused index.
  task automatic program_code(input logic [CHIP_REGS-1:0][CHIP_REG_W-1:0] words);
    write_reg(REG_CODE_CHIPS_0, words[0]);
    write_reg(REG_CODE_CHIPS_1, words[1]);
    write_reg(REG_CODE_CHIPS_2, words[2]);
    write_reg(REG_CODE_CHIPS_3, words[3]);
    write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
              {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_part();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      2:       return SAMPLE_BITS'($urandom_range(0, 32) - 16);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CHIP_REG_W-1:0] rand_code_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // The window fills with the most negative sample under the reset code (all +1);
  // only the item that completes the window gives a result.
  task automatic test_window_fill();
    in_item_t s;
    s.sample_re = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    s.sample_im = s.sample_re;
    repeat (TAPS) send_sample(s);
  endtask

  // Each chip value over a window of extreme samples, then mixed extreme and small samples under a random code.
  task automatic test_chip_codes();
    chip_e                                 chips [4];
    logic [1:0]                            cb;
    logic [SAMPLE_BITS-1:0]                lo;
    logic [SAMPLE_BITS-1:0]                hi;
    in_item_t                              s;
    logic [CHIP_REGS-1:0][CHIP_REG_W-1:0]  words;
    chips = '{CHIP_POS_ONE, CHIP_NEG_J, CHIP_NEG_ONE, CHIP_POS_J};
    lo = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    hi = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    foreach (chips[i]) begin
      cb = chips[i];
      wait_idle();
      program_code({CHIP_REGS{{32{cb}}}});
      s.sample_re = lo;
      s.sample_im = lo;
      send_sample(s);
    end
    wait_idle();
    foreach (words[i]) words[i] = {$urandom, $urandom};
    program_code(words);
    s = '{hi, hi};
    send_sample(s);
    s = '{hi, lo};
    send_sample(s);
    s = '{'0, '0};
    send_sample(s);
    s = '{'1, SAMPLE_BITS'(1)};
    send_sample(s);
    s = '{lo, hi};
    send_sample(s);
    s = '{hi, '1};
    send_sample(s);
  endtask

  task automatic test_random_phases(input int phases, input int items_per_phase);
    logic [CHIP_REGS-1:0][CHIP_REG_W-1:0] words;
    in_item_t                             s;
    repeat (phases) begin
      wait_idle();
      foreach (words[i]) words[i] = rand_code_word();
      program_code(words);
      repeat (items_per_phase) begin
        s.sample_re = rand_part();
        s.sample_im = rand_part();
        send_sample(s);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct  = 35;
    recv_stall_pct = 73;
    test_window_fill();
    test_chip_codes();
    test_random_phases(4, 22);
    send_idle_pct  = 73;
    recv_stall_pct = 35;
    test_random_phases(4, 22);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_phases(4, 22);
    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
